FILE: hw/rtl/wsg8_pkg.sv
// wsg8_pkg: shared types, codes and default sizes of the 8-direction word search unit
// depends on nothing; imported by the top level, the controller and the datapath
package wsg8_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_WORD = 8;

    // fixed field and register widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int DIM_W   = 6;
    localparam int LEN_W   = 4;
    localparam int WORD_W  = 64;
    localparam int WORD_CH = 8;
    localparam int CFG_IDX_W = 2;
    // signed walk position, wide enough for -1 up to 256
    localparam int POS_W   = 10;
    // width of the row * cols + col address product before truncation
    localparam int AF_W    = 2 * POS_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_CHARS = 2'd3;

    // input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // last of the eight walk directions
    localparam logic [2:0] DIR_LAST = 3'd7;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_RESULT
    } ctl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic wr;         // store the incoming cell
        logic start;      // capture the query start cell
        logic issue;      // read the cell at the walk position and step
        logic next_dir;   // restart the walk in the next direction
        logic set_found;  // record the query outcome
        logic found_val;
        logic out_load;   // move the outcome into the output register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic query_ok;    // start cell in area and word not empty
        logic pend_valid;  // a read is waiting for comparison
        logic pend_match;
        logic pend_last;   // waiting read holds the last word character
        logic issue_oob;   // walk position left the area
        logic all_issued;  // every character of the direction was read
        logic last_dir;
        logic out_free;    // output register can take a new transaction
    } dp_status_t;

    // row step of each direction
    function automatic logic signed [1:0] dir_dr(input logic [2:0] dir);
        logic signed [1:0] d;
        unique case (dir)
            3'd0, 3'd1, 3'd2: d = -2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // column step of each direction
    function automatic logic signed [1:0] dir_dc(input logic [2:0] dir);
        logic signed [1:0] d;
        unique case (dir)
            3'd0, 3'd3, 3'd5: d = -2'sd1;
            3'd1, 3'd6:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/word_search_grid_8dir_unit.sv
// word search unit: a write transaction stores one grid cell; a query whose start cell
// is outside the area, or whose word is empty, goes straight to its result, otherwise
// the walk makes one grid ram read per cycle, up to L reads per direction for word
// length L, over up to eight directions. one transaction at a time; the output register
// holds a result while the next transaction is taken. reset clears the controller,
// the output valid and the configuration (1 row, 1 column, length 1, word zero); the
// grid ram is not cleared
module word_search_grid_8dir_unit
    import wsg8_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_WORD = DEF_MAX_WORD
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [ROW_W-1:0]     cell_row,
    input  logic [COL_W-1:0]     cell_col,
    input  logic [CHAR_W-1:0]    cell_char,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     hit_row,
    output logic [COL_W-1:0]     hit_col,
    output logic                 present
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // controller
    wsg8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    wsg8_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_WORD (MAX_WORD)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cell_char (cell_char),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .hit_row   (hit_row),
        .hit_col   (hit_col),
        .present   (present),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

FILE: hw/rtl/wsg8_ram.sv
// wsg8_ram: generic single-port ram with registered read
// depends on nothing
module wsg8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hw/rtl/wsg8_ctrl.sv
// wsg8_ctrl: controller state machine of the word search unit
// depends on wsg8_pkg; drives datapath commands from datapath status
module wsg8_ctrl
    import wsg8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       action,
    output logic       in_stall,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                priority if (!st.query_ok)
                begin
                    cmd.set_found = 1'b1;
                    cmd.found_val = 1'b0;
                    state_next    = ST_RESULT;
                end
                else if (st.pend_valid && st.pend_match && st.pend_last)
                begin
                    cmd.set_found = 1'b1;
                    cmd.found_val = 1'b1;
                    state_next    = ST_RESULT;
                end
                else if ((st.pend_valid && !st.pend_match) ||
                         (!st.all_issued && st.issue_oob))
                begin
                    // this direction fails
                    if (st.last_dir)
                    begin
                        cmd.set_found = 1'b1;
                        cmd.found_val = 1'b0;
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        cmd.next_dir = 1'b1;
                    end
                end
                else if (!st.all_issued)
                begin
                    cmd.issue = 1'b1;
                end
                else
                begin
                    // wait for the last read to come back
                end
            end
            ST_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // new transactions only while idle
    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: hw/rtl/wsg8_dpath.sv
// wsg8_dpath: datapath of the word search unit: config registers, walk counters,
// grid ram, character compare and output register; depends on wsg8_pkg and wsg8_ram
module wsg8_dpath
    import wsg8_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_WORD = DEF_MAX_WORD
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [ROW_W-1:0]     cell_row,
    input  logic [COL_W-1:0]     cell_col,
    input  logic [CHAR_W-1:0]    cell_char,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [ROW_W-1:0]     hit_row,
    output logic [COL_W-1:0]     hit_col,
    output logic                 present,
    input  dp_cmd_t              cmd,
    output dp_status_t           st
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = $clog2(MAX_WORD + 1);

    // configuration registers
    logic [DIM_W-1:0]  num_rows_reg;
    logic [DIM_W-1:0]  num_cols_reg;
    logic [LEN_W-1:0]  word_len_reg;
    logic [WORD_W-1:0] word_chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= DIM_W'(1);
            num_cols_reg   <= DIM_W'(1);
            word_len_reg   <= LEN_W'(1);
            word_chars_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_ROWS:   num_rows_reg   <= cfg_data[DIM_W-1:0];
                CFG_NUM_COLS:   num_cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_WORD_LEN:   word_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_WORD_CHARS: word_chars_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective area and word length, saturated at the maxima
    logic [8:0]    rows_eff;
    logic [8:0]    cols_eff;
    logic [KW-1:0] len_eff;

    assign rows_eff = ({3'b0, num_rows_reg} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS)
                                                            : {3'b0, num_rows_reg};
    assign cols_eff = ({3'b0, num_cols_reg} > 9'(MAX_COLS)) ? 9'(MAX_COLS)
                                                            : {3'b0, num_cols_reg};
    assign len_eff  = ({2'b0, word_len_reg} > 6'(MAX_WORD)) ? KW'(MAX_WORD)
                                                            : KW'(word_len_reg);

    // walk state
    logic [ROW_W-1:0]        r0_reg;
    logic [COL_W-1:0]        c0_reg;
    logic signed [POS_W-1:0] pos_r_reg, pos_r_next;
    logic signed [POS_W-1:0] pos_c_reg, pos_c_next;
    logic [2:0]              dir_reg, dir_next;
    logic [KW-1:0]           k_reg, k_next;
    logic                    pend_valid_reg;
    logic [KW-1:0]           pend_k_reg;
    logic                    found_reg;
    logic signed [1:0]       dr;
    logic signed [1:0]       dc;

    assign dr = dir_dr(dir_reg);
    assign dc = dir_dc(dir_reg);

    // walk counter updates
    always_comb
    begin
        pos_r_next = pos_r_reg;
        pos_c_next = pos_c_reg;
        dir_next   = dir_reg;
        k_next     = k_reg;
        priority if (cmd.start)
        begin
            pos_r_next = signed'(POS_W'(cell_row));
            pos_c_next = signed'(POS_W'(cell_col));
            dir_next   = '0;
            k_next     = '0;
        end
        else if (cmd.next_dir)
        begin
            pos_r_next = signed'(POS_W'(r0_reg));
            pos_c_next = signed'(POS_W'(c0_reg));
            dir_next   = dir_reg + 3'd1;
            k_next     = '0;
        end
        else if (cmd.issue)
        begin
            pos_r_next = pos_r_reg + POS_W'(dr);
            pos_c_next = pos_c_reg + POS_W'(dc);
            k_next     = k_reg + KW'(1);
        end
        else
        begin
            // hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r0_reg <= cell_row;
            c0_reg <= cell_col;
        end
        if (cmd.issue)
        begin
            pend_k_reg <= k_reg;
        end
        if (cmd.set_found)
        begin
            found_reg <= cmd.found_val;
        end
        pos_r_reg <= pos_r_next;
        pos_c_reg <= pos_c_next;
        dir_reg   <= dir_next;
        k_reg     <= k_next;
    end

    // bounds of the walk position
    logic signed [POS_W-1:0] rows_lim;
    logic signed [POS_W-1:0] cols_lim;

    assign rows_lim = signed'(POS_W'(rows_eff));
    assign cols_lim = signed'(POS_W'(cols_eff));

    // grid ram addressing: incoming cell on a write, walk position otherwise
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_rdata;
    logic [AF_W-1:0]   wr_addr_full;
    logic [AF_W-1:0]   rd_addr_full;

    assign wr_addr_full = AF_W'(cell_row) * AF_W'(MAX_COLS) + AF_W'(cell_col);
    assign rd_addr_full = AF_W'(pos_r_reg[POS_W-2:0]) * AF_W'(MAX_COLS)
                        + AF_W'(pos_c_reg[POS_W-2:0]);
    assign mem_addr = cmd.wr ? ADDR_W'(wr_addr_full) : ADDR_W'(rd_addr_full);
    assign mem_we   = cmd.wr && ({4'b0, cell_row} < 9'(MAX_ROWS))
                             && ({4'b0, cell_col} < 9'(MAX_COLS));

    wsg8_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cell_char),
        .rdata (mem_rdata)
    );

    // word character of the waiting read; characters past the eighth read as zero
    logic [5:0]        pk6;
    logic [CHAR_W-1:0] word_ch;

    assign pk6     = 6'(pend_k_reg);
    assign word_ch = (pk6 < 6'(WORD_CH)) ? word_chars_reg[pk6[2:0] * CHAR_W +: CHAR_W]
                                         : '0;

    // output register
    logic             out_valid_reg;
    logic [ROW_W-1:0] hit_row_reg;
    logic [COL_W-1:0] hit_col_reg;
    logic             present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hit_row_reg <= r0_reg;
            hit_col_reg <= c0_reg;
            present_reg <= found_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_row   = hit_row_reg;
    assign hit_col   = hit_col_reg;
    assign present   = present_reg;

    // status to the controller
    always_comb
    begin
        st.query_ok   = (len_eff != '0) && ({4'b0, r0_reg} < rows_eff)
                                        && ({4'b0, c0_reg} < cols_eff);
        st.pend_valid = pend_valid_reg;
        st.pend_match = (mem_rdata == word_ch);
        st.pend_last  = (KW'(pend_k_reg + KW'(1)) == len_eff);
        st.issue_oob  = pos_r_reg[POS_W-1] || pos_c_reg[POS_W-1]
                     || (pos_r_reg >= rows_lim) || (pos_c_reg >= cols_lim);
        st.all_issued = (k_reg == len_eff);
        st.last_dir   = (dir_reg == DIR_LAST);
        st.out_free   = !out_valid_reg || !out_stall;
    end

endmodule
